/* src/stkrs_pkg.sv */
package stkrs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic        [1:0]  operation;
        logic        [9:0]  entry_index;
        logic signed [63:0] entry_key;
        logic signed [63:0] entry_value;
        logic signed [63:0] low_key;
        logic signed [63:0] high_key;
        logic        [9:0]  window_start;
        logic        [10:0] window_length;
    } request_t;

    typedef struct packed {
        logic        [10:0] first_index;
        logic        [10:0] end_index;
        logic signed [63:0] read_key;
        logic signed [63:0] read_value;
    } result_t;

    // One access to the record table.
    typedef struct packed {
        logic                write;
        logic [ADDR_W-1:0]   addr;
        logic signed [63:0]  wkey;
        logic signed [63:0]  wvalue;
    } mem_req_t;

    // Control of the shared bound-search unit.
    typedef struct packed {
        logic init;
        logic step;
        logic inclusive;
    } bound_ctrl_t;

endpackage

/* src/sorted_table_key_range_search_core.sv */
// Sorted key/value table with inclusive key-range search.
// Commands enter on request, taken at a rising edge where start is high and busy
// is low. A load writes one record in the accept cycle and gives no result; busy
// stays low, so the next beat can follow at once. A read returns the record from
// the registered table read port through the result register. A query runs a
// lower-bound and then an upper-bound binary search over the clamped window and
// returns first_index and end_index. Each search probe is an issue state (memory
// address) and then a wait state (compare of the registered read data), and a
// final issue state closes the search; the single memory read port of the
// 1024-entry table serialises the probes. The upper search is skipped when
// high_key is below low_key.
// Each result beat is on result for exactly one cycle with done high; the
// receiver cannot stall it. busy is high from accept of a read or query until
// the cycle of its done strobe.
// Reset clears the sequencer and the bound unit only; table contents are undefined until loaded.
module sorted_table_key_range_search_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  stkrs_pkg::request_t    request,
    output logic                   busy,
    output logic                   done,
    output stkrs_pkg::result_t     result
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_LOW_ISSUE = 3'd1;
    localparam logic [2:0] ST_LOW_WAIT  = 3'd2;
    localparam logic [2:0] ST_UP_ISSUE  = 3'd3;
    localparam logic [2:0] ST_UP_WAIT   = 3'd4;
    localparam logic [2:0] ST_READ_WAIT = 3'd5;

    localparam logic [stkrs_pkg::POS_W-1:0] DEPTH_POS =
        stkrs_pkg::POS_W'(stkrs_pkg::TABLE_DEPTH);

    logic [2:0]                     state_reg, state_next;
    logic                           done_reg, done_next;
    stkrs_pkg::result_t             result_reg, result_next;
    logic signed [63:0]             low_reg, low_next;
    logic signed [63:0]             high_reg, high_next;
    logic                           empty_range_reg, empty_range_next;
    logic [stkrs_pkg::POS_W-1:0]    s_reg, s_next;
    logic [stkrs_pkg::POS_W-1:0]    e_reg, e_next;
    logic [stkrs_pkg::POS_W-1:0]    first_reg, first_next;

    logic                           accept;
    logic [stkrs_pkg::POS_W-1:0]    s_clamp;
    logic [stkrs_pkg::POS_W:0]      e_sum;
    logic [stkrs_pkg::POS_W-1:0]    e_clamp;

    stkrs_pkg::mem_req_t            mem_req;
    logic signed [63:0]             rd_key;
    logic signed [63:0]             rd_value;

    stkrs_pkg::bound_ctrl_t         bctrl;
    logic [stkrs_pkg::POS_W-1:0]    b_init_lo;
    logic [stkrs_pkg::POS_W-1:0]    b_init_hi;
    logic signed [63:0]             b_bound;
    logic                           b_active;
    logic [stkrs_pkg::ADDR_W-1:0]   b_mid;
    logic [stkrs_pkg::POS_W-1:0]    b_lo;

    assign accept = start && !busy;

    // Window start and end saturate at the table depth.
    always_comb
    begin
        s_clamp = stkrs_pkg::POS_W'(request.window_start);
        if (s_clamp > DEPTH_POS)
            s_clamp = DEPTH_POS;
        e_sum   = {1'b0, s_clamp} + (stkrs_pkg::POS_W + 1)'(request.window_length);
        e_clamp = (e_sum > {1'b0, DEPTH_POS}) ? DEPTH_POS : e_sum[stkrs_pkg::POS_W-1:0];
    end

    stkrs_table u_table (
        .clk      (clk),
        .req      (mem_req),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    stkrs_bound_unit u_bound (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (bctrl),
        .init_lo   (b_init_lo),
        .init_hi   (b_init_hi),
        .bound     (b_bound),
        .probe_key (rd_key),
        .active    (b_active),
        .mid       (b_mid),
        .lo        (b_lo)
    );

    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        empty_range_next = empty_range_reg;
        s_next           = s_reg;
        e_next           = e_reg;
        first_next       = first_reg;

        mem_req.write  = 1'b0;
        mem_req.addr   = b_mid;
        mem_req.wkey   = request.entry_key;
        mem_req.wvalue = request.entry_value;

        bctrl.init      = 1'b0;
        bctrl.step      = 1'b0;
        bctrl.inclusive = 1'b0;
        b_init_lo       = s_reg;
        b_init_hi       = e_reg;
        b_bound         = low_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.addr = request.entry_index[stkrs_pkg::ADDR_W-1:0];
                if (accept)
                begin
                    unique case (request.operation)
                        stkrs_pkg::OP_LOAD:
                        begin
                            mem_req.write = 1'b1;
                        end
                        stkrs_pkg::OP_QUERY:
                        begin
                            low_next         = request.low_key;
                            high_next        = request.high_key;
                            empty_range_next = request.high_key < request.low_key;
                            s_next           = s_clamp;
                            e_next           = e_clamp;
                            bctrl.init       = 1'b1;
                            b_init_lo        = s_clamp;
                            b_init_hi        = e_clamp;
                            state_next       = ST_LOW_ISSUE;
                        end
                        stkrs_pkg::OP_READ:
                        begin
                            state_next = ST_READ_WAIT;
                        end
                        default:
                        begin
                            // The unused code is dropped without a result.
                        end
                    endcase
                end
            end

            ST_LOW_ISSUE:
            begin
                if (b_active)
                    state_next = ST_LOW_WAIT;
                else
                begin
                    first_next = b_lo;
                    if (empty_range_reg)
                    begin
                        result_next.first_index = 11'(b_lo);
                        result_next.end_index   = 11'(b_lo);
                        result_next.read_key    = '0;
                        result_next.read_value  = '0;
                        done_next               = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        bctrl.init = 1'b1;
                        state_next = ST_UP_ISSUE;
                    end
                end
            end

            ST_LOW_WAIT:
            begin
                bctrl.step = 1'b1;
                state_next = ST_LOW_ISSUE;
            end

            ST_UP_ISSUE:
            begin
                if (b_active)
                    state_next = ST_UP_WAIT;
                else
                begin
                    // An unsorted window can leave the upper bound below the lower one.
                    result_next.first_index = 11'(first_reg);
                    result_next.end_index   = (b_lo < first_reg) ? 11'(first_reg) : 11'(b_lo);
                    result_next.read_key    = '0;
                    result_next.read_value  = '0;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            ST_UP_WAIT:
            begin
                bctrl.step      = 1'b1;
                bctrl.inclusive = 1'b1;
                b_bound         = high_reg;
                state_next      = ST_UP_ISSUE;
            end

            ST_READ_WAIT:
            begin
                result_next.first_index = '0;
                result_next.end_index   = '0;
                result_next.read_key    = rd_key;
                result_next.read_value  = rd_value;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg      <= result_next;
        low_reg         <= low_next;
        high_reg        <= high_next;
        empty_range_reg <= empty_range_next;
        s_reg           <= s_next;
        e_reg           <= e_next;
        first_reg       <= first_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/stkrs_table.sv */
module stkrs_table (
    input  logic                      clk,
    input  stkrs_pkg::mem_req_t       req,
    output logic signed [63:0]        rd_key,
    output logic signed [63:0]        rd_value
);

    logic signed [63:0] key_mem   [stkrs_pkg::TABLE_DEPTH];
    logic signed [63:0] value_mem [stkrs_pkg::TABLE_DEPTH];
    logic signed [63:0] rd_key_reg;
    logic signed [63:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (req.write)
        begin
            key_mem[req.addr]   <= req.wkey;
            value_mem[req.addr] <= req.wvalue;
        end
        rd_key_reg   <= key_mem[req.addr];
        rd_value_reg <= value_mem[req.addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

/* src/stkrs_bound_unit.sv */
module stkrs_bound_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stkrs_pkg::bound_ctrl_t            ctrl,
    input  logic [stkrs_pkg::POS_W-1:0]       init_lo,
    input  logic [stkrs_pkg::POS_W-1:0]       init_hi,
    input  logic signed [63:0]                bound,
    input  logic signed [63:0]                probe_key,
    output logic                              active,
    output logic [stkrs_pkg::ADDR_W-1:0]      mid,
    output logic [stkrs_pkg::POS_W-1:0]       lo
);

    logic [stkrs_pkg::POS_W-1:0] lo_reg, lo_next;
    logic [stkrs_pkg::POS_W-1:0] hi_reg, hi_next;
    logic [stkrs_pkg::POS_W-1:0] diff;
    logic [stkrs_pkg::POS_W-1:0] mid_pos;
    logic                        go_right;

    assign diff    = hi_reg - lo_reg;
    assign mid_pos = lo_reg + (diff >> 1);

    // Lower bound moves right past keys below the bound; upper bound also past equal keys.
    assign go_right = ctrl.inclusive ? !(bound < probe_key) : (probe_key < bound);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.init)
        begin
            lo_next = init_lo;
            hi_next = init_hi;
        end
        else if (ctrl.step)
        begin
            if (go_right)
                lo_next = mid_pos + stkrs_pkg::POS_W'(1);
            else
                hi_next = mid_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign active = lo_reg < hi_reg;
    assign mid    = mid_pos[stkrs_pkg::ADDR_W-1:0];
    assign lo     = lo_reg;

endmodule
